// ===== hdl/assert_macros.svh =====
// Assertion macros used by the fragment table controller RTL.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked on every rising clock edge outside reset.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");
// Next-cycle implication.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");
`endif

// ===== hdl/fsft_pkg.sv =====
// Package for the free-space fragment table: sizes, codes and shared types.
// No dependencies.
package fsft_pkg;
	localparam int TableEntries = 4096;
	localparam int IdxW = $clog2(TableEntries);
	localparam int CntW = IdxW + 1;
	localparam int AddrW = 31;
	localparam int FreeW = 16;
	localparam int LenW = 24;
	localparam int NumW = 12;
	localparam int CfgAw = 3;
	localparam logic [FreeW-1:0] CntMax = '1;

	typedef enum logic [1:0] {
		OP_ADD = 2'd0,
		OP_COUNT = 2'd1,
		OP_READ = 2'd2,
		OP_CLEAR = 2'd3
	} op_t;

	localparam logic [CfgAw-1:0] REG_WINDOW = 3'd0;
	localparam logic [CfgAw-1:0] REG_PRUNE = 3'd4;

	typedef struct packed {
		logic [FreeW-1:0] window_size;
		logic [CntW-1:0] prune_threshold;
	} cfg_t;

	typedef struct packed {
		logic [AddrW-1:0] start;
		logic [FreeW-1:0] free;
		logic [FreeW-1:0] alloc;
	} entry_t;

	// memory port bundle from controller to table memory
	typedef struct packed {
		logic rd_en;
		logic [IdxW-1:0] rd_addr;
		logic wr_en;
		logic [IdxW-1:0] wr_addr;
		entry_t wr_data;
	} mem_req_t;
endpackage

// ===== hdl/free_space_fragment_table.sv =====
// Free-space fragment table: builds and searches a fragment table in one RAM.
// One item at a time; busy stays high until its result strobe (clear and a count
// on an empty table give the strobe without raising busy); the table RAM
// read/write port sets the rate. Receiver cannot stall the result strobe.
// Reset empties the table at once (no clearing pass); registers reset to defaults.
// Depends on fsft_pkg, fsft_cfg, fsft_mem, fsft_ctrl.
module free_space_fragment_table import fsft_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic psel,
	input logic penable,
	input logic pwrite,
	input logic [CfgAw-1:0] paddr,
	input logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic pready,
	input logic start,
	output logic busy,
	input logic [1:0] opcode,
	input logic [AddrW-1:0] block_addr,
	input logic [LenW-1:0] extent_length,
	input logic [NumW-1:0] entry_number,
	output logic done,
	output logic entry_valid,
	output logic [AddrW-1:0] entry_start,
	output logic [FreeW-1:0] entry_free,
	output logic [FreeW-1:0] entry_alloc,
	output logic hit,
	output logic table_full,
	output logic [CntW-1:0] fragment_count
);
	cfg_t cfg;
	mem_req_t req;
	entry_t rd_data;

	fsft_cfg u_cfg (
		.clk, .arst_n, .psel, .penable, .pwrite, .paddr, .pwdata,
		.prdata, .pready, .cfg
	);

	fsft_mem u_mem (.clk, .req, .rd_data);

	fsft_ctrl u_ctrl (
		.clk, .arst_n, .cfg, .start, .busy, .opcode, .block_addr,
		.extent_length, .entry_number, .req, .rd_data, .done, .entry_valid,
		.entry_start, .entry_free, .entry_alloc, .hit, .table_full, .fragment_count
	);
endmodule

// ===== hdl/fsft_cfg.sv =====
// APB configuration registers of the fragment table.
// Depends on fsft_pkg.
module fsft_cfg import fsft_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic psel,
	input logic penable,
	input logic pwrite,
	input logic [CfgAw-1:0] paddr,
	input logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic pready,
	output cfg_t cfg
);
	logic [FreeW-1:0] window_q;
	logic [CntW-1:0] prune_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_q <= FreeW'(248);
			prune_q <= CntW'(1000);
		end else if (psel && penable && pwrite) begin
			if (paddr == REG_WINDOW) window_q <= pwdata[FreeW-1:0];
			else if (paddr == REG_PRUNE) prune_q <= pwdata[CntW-1:0];
		end
	end

	always_comb begin
		case (paddr)
			REG_WINDOW: prdata = {{(32-FreeW){1'b0}}, window_q};
			REG_PRUNE: prdata = {{(32-CntW){1'b0}}, prune_q};
			default: prdata = '0;
		endcase
	end

	assign pready = 1'b1;
	assign cfg.window_size = window_q;
	assign cfg.prune_threshold = prune_q;
endmodule

// ===== hdl/fsft_mem.sv =====
// Fragment table memory: one write and one registered read port.
// Depends on fsft_pkg.
module fsft_mem import fsft_pkg::*; (
	input logic clk,
	input mem_req_t req,
	output entry_t rd_data
);
	entry_t mem [TableEntries];

	always_ff @(posedge clk) begin
		if (req.wr_en) mem[req.wr_addr] <= req.wr_data;
		if (req.rd_en) rd_data <= mem[req.rd_addr];
	end
endmodule

// ===== hdl/fsft_ctrl.sv =====
// Sequencer for add, count (binary search), read and clear items.
// Depends on fsft_pkg and assert_macros.svh.
`include "assert_macros.svh"
module fsft_ctrl import fsft_pkg::*; (
	input logic clk,
	input logic arst_n,
	input cfg_t cfg,
	input logic start,
	output logic busy,
	input logic [1:0] opcode,
	input logic [AddrW-1:0] block_addr,
	input logic [LenW-1:0] extent_length,
	input logic [NumW-1:0] entry_number,
	output mem_req_t req,
	input entry_t rd_data,
	output logic done,
	output logic entry_valid,
	output logic [AddrW-1:0] entry_start,
	output logic [FreeW-1:0] entry_free,
	output logic [FreeW-1:0] entry_alloc,
	output logic hit,
	output logic table_full,
	output logic [CntW-1:0] fragment_count
);
	typedef enum logic [3:0] {
		ST_IDLE, ST_ADD_RD, ST_ADD, ST_RD_WAIT, ST_READ,
		ST_C_TOP, ST_C_BOT, ST_C_LOOP, ST_C_PROBE, ST_C_FIN, ST_C_RMW
	} state_t;

	state_t state_q;
	logic [1:0] op_q;
	logic [AddrW-1:0] addr_q;
	logic [LenW-1:0] len_q;
	logic [NumW-1:0] num_q;
	logic [CntW-1:0] used_q;
	logic newest_valid_q, newest_single_q;
	logic [IdxW-1:0] top_q, bot_q, mid_q;
	logic done_q, valid_q, hit_q, full_q;
	entry_t ent_q;

	logic [AddrW:0] win_end;
	logic in_win;
	logic [LenW:0] sum;
	logic [FreeW-1:0] sat_free;
	logic [IdxW-1:0] newest_idx;
	logic [CntW-1:0] used_pruned;

	assign win_end = {1'b0, rd_data.start} + (AddrW+1)'(cfg.window_size);
	assign in_win = {1'b0, addr_q} < win_end;
	assign sum = {1'b0, len_q} + (LenW+1)'(rd_data.free);
	assign sat_free = (sum > (LenW+1)'(cfg.window_size)) ? cfg.window_size
		: sum[FreeW-1:0];
	assign newest_idx = IdxW'(used_q - CntW'(1));
	assign used_pruned = (newest_single_q && used_q > cfg.prune_threshold
		&& used_q != '0) ? used_q - CntW'(1) : used_q;

	always_comb begin
		req = '0;
		case (state_q)
			ST_IDLE: begin
				req.rd_en = 1'b1;
				req.rd_addr = (opcode == OP_READ) ? IdxW'(entry_number) : newest_idx;
			end
			ST_C_BOT: begin
				req.rd_en = 1'b1;
				req.rd_addr = '0;
			end
			ST_C_LOOP: begin
				req.rd_en = 1'b1;
				req.rd_addr = (bot_q < mid_q) ? mid_q : bot_q;
			end
			ST_ADD: begin
				if (!(newest_valid_q && used_q != '0 && in_win)
					&& len_q < LenW'(cfg.window_size)
					&& used_pruned < CntW'(TableEntries)) begin
					req.wr_en = 1'b1;
					req.wr_addr = IdxW'(used_pruned);
					req.wr_data.start = addr_q;
					req.wr_data.free = len_q[FreeW-1:0];
					req.wr_data.alloc = '0;
				end else if (newest_valid_q && used_q != '0 && in_win) begin
					req.wr_en = 1'b1;
					req.wr_addr = newest_idx;
					req.wr_data = rd_data;
					req.wr_data.free = sat_free;
				end
			end
			ST_C_RMW: begin
				req.wr_en = hit_q;
				req.wr_addr = bot_q;
				req.wr_data = ent_q;
				req.wr_data.alloc = (ent_q.alloc < CntMax) ? ent_q.alloc + FreeW'(1)
					: ent_q.alloc;
			end
			default: req = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			used_q <= '0;
			newest_valid_q <= 1'b0;
			newest_single_q <= 1'b0;
			done_q <= 1'b0;
			valid_q <= 1'b0;
			hit_q <= 1'b0;
			full_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				ST_IDLE: if (start) begin
					op_q <= opcode;
					addr_q <= block_addr;
					len_q <= extent_length;
					num_q <= entry_number;
					valid_q <= 1'b0;
					hit_q <= 1'b0;
					full_q <= 1'b0;
					case (opcode)
						OP_ADD: state_q <= ST_ADD_RD;
						OP_READ: state_q <= ST_RD_WAIT;
						OP_COUNT: begin
							top_q <= newest_idx;
							bot_q <= '0;
							mid_q <= IdxW'(newest_idx >> 1);
							if (used_q == '0) begin
								done_q <= 1'b1;
							end else begin
								state_q <= ST_C_TOP;
							end
						end
						default: begin
							used_q <= '0;
							newest_valid_q <= 1'b0;
							newest_single_q <= 1'b0;
							done_q <= 1'b1;
						end
					endcase
				end
				ST_ADD_RD: state_q <= ST_ADD;
				ST_ADD: begin
					state_q <= ST_IDLE;
					done_q <= 1'b1;
					if (newest_valid_q && used_q != '0 && in_win) begin
						newest_single_q <= 1'b0;
					end else if (len_q < LenW'(cfg.window_size)) begin
						used_q <= used_pruned;
						if (used_pruned >= CntW'(TableEntries)) begin
							full_q <= 1'b1;
						end else begin
							used_q <= used_pruned + CntW'(1);
							newest_valid_q <= 1'b1;
							newest_single_q <= 1'b1;
						end
					end
				end
				ST_RD_WAIT: state_q <= ST_READ;
				ST_READ: begin
					state_q <= ST_IDLE;
					done_q <= 1'b1;
					valid_q <= CntW'(num_q) < used_q;
					ent_q <= rd_data;
				end
				ST_C_TOP: state_q <= ST_C_BOT;
				ST_C_BOT: begin
					// rd_data holds entry top
					if (rd_data.start <= addr_q) begin
						bot_q <= top_q;
						state_q <= ST_C_LOOP;
					end else begin
						state_q <= ST_C_PROBE;
					end
				end
				ST_C_PROBE: begin
					// rd_data holds entry 0
					if (rd_data.start > addr_q) begin
						state_q <= ST_IDLE;
						done_q <= 1'b1;
					end else begin
						state_q <= ST_C_LOOP;
					end
				end
				ST_C_LOOP: state_q <= ST_C_FIN;
				ST_C_FIN: begin
					if (bot_q < mid_q) begin
						if (rd_data.start < addr_q) bot_q <= mid_q;
						else top_q <= mid_q;
						mid_q <= (rd_data.start < addr_q)
							? IdxW'(({1'b0, top_q} + {1'b0, mid_q}) >> 1)
							: IdxW'(({1'b0, mid_q} + {1'b0, bot_q}) >> 1);
						state_q <= ST_C_LOOP;
					end else begin
						hit_q <= (addr_q >= rd_data.start) && in_win;
						ent_q <= rd_data;
						state_q <= ST_C_RMW;
					end
				end
				ST_C_RMW: begin
					state_q <= ST_IDLE;
					done_q <= 1'b1;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign busy = state_q != ST_IDLE;
	assign done = done_q;
	assign entry_valid = (op_q == OP_READ) && valid_q;
	assign entry_start = entry_valid ? ent_q.start : '0;
	assign entry_free = entry_valid ? ent_q.free : '0;
	assign entry_alloc = entry_valid ? ent_q.alloc : '0;
	assign hit = (op_q == OP_COUNT) && hit_q;
	assign table_full = (op_q == OP_ADD) && full_q;
	assign fragment_count = done_q ? used_q : '0;

	`ASSERT_IMPL(a_used_bound, clk, arst_n, 1'b1, used_q <= CntW'(TableEntries))
	`ASSERT_IMPL(a_done_idle, clk, arst_n, done_q, state_q == ST_IDLE)
	`ASSERT_IMPL(a_newest_nonzero, clk, arst_n, newest_valid_q, used_q != '0)
	`ASSERT_IMPL(a_search_order, clk, arst_n, state_q == ST_C_LOOP, bot_q <= top_q)
endmodule

// ===== tb/sv/free_space_fragment_table_tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for free_space_fragment_table: directed and random
// command streams, APB register writes, in-line prediction of every result.
// Depends on fsft_pkg and the free_space_fragment_table RTL.
module free_space_fragment_table_tb;
	import fsft_pkg::*;

	localparam int WatchdogLimit = 5000;
	localparam int DrainCycles = 40;

	typedef struct packed {
		bit ev;
		bit [AddrW-1:0] st;
		bit [FreeW-1:0] fr;
		bit [FreeW-1:0] al;
		bit h;
		bit tf;
		bit [CntW-1:0] fc;
	} frag_result_t;

	logic clk = 0;
	logic arst_n;
	logic psel, penable, pwrite;
	logic [CfgAw-1:0] paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic pready;
	logic start;
	logic busy;
	logic [1:0] opcode;
	logic [AddrW-1:0] block_addr;
	logic [LenW-1:0] extent_length;
	logic [NumW-1:0] entry_number;
	logic done, entry_valid, hit, table_full;
	logic [AddrW-1:0] entry_start;
	logic [FreeW-1:0] entry_free, entry_alloc;
	logic [CntW-1:0] fragment_count;

	free_space_fragment_table dut (.*);

	always #5 clk = ~clk;

	// predictor state
	bit [AddrW-1:0] frag_start [TableEntries];
	bit [FreeW-1:0] frag_free [TableEntries];
	bit [FreeW-1:0] frag_alloc [TableEntries];
	int unsigned used_cnt;
	bit newest_ok, newest_lone;
	bit [FreeW-1:0] win_size;
	bit [CntW-1:0] prune_lvl;

	frag_result_t pending_results[$];
	int errors;
	int idle_pct;
	int quiet_cycles;

	function automatic bit in_win(bit [AddrW-1:0] base, bit [AddrW-1:0] blk);
		return {2'b0, blk} < ({2'b0, base} + {17'b0, win_size});
	endfunction

	function automatic int locate_fragment(bit [AddrW-1:0] blk);
		int lo, hi, mid;
		if (used_cnt == 0) return -1;
		hi = used_cnt - 1;
		lo = 0;
		mid = (hi + lo) / 2;
		if (frag_start[hi] <= blk) lo = hi;
		else if (frag_start[lo] > blk) return -1;
		while (lo < mid) begin
			if (frag_start[mid] < blk) lo = mid;
			else hi = mid;
			mid = (hi + lo) / 2;
		end
		if (blk >= frag_start[lo] && in_win(frag_start[lo], blk)) return lo;
		return -1;
	endfunction

	function automatic bit add_extent(bit [AddrW-1:0] a, bit [LenW-1:0] l);
		int k;
		bit [24:0] sum;
		if (newest_ok && used_cnt > 0) begin
			k = used_cnt - 1;
			if (in_win(frag_start[k], a)) begin
				sum = frag_free[k] + l;
				if (sum > win_size) sum = win_size;
				frag_free[k] = sum[FreeW-1:0];
				newest_lone = 0;
				return 0;
			end
		end
		if (l >= win_size) return 0;
		if (newest_lone && used_cnt > prune_lvl && used_cnt > 0) used_cnt--;
		if (used_cnt >= TableEntries) return 1;
		frag_start[used_cnt] = a;
		frag_free[used_cnt] = l[FreeW-1:0];
		frag_alloc[used_cnt] = 0;
		used_cnt++;
		newest_ok = 1;
		newest_lone = 1;
		return 0;
	endfunction

	function automatic frag_result_t predict_fragment(op_t op, bit [AddrW-1:0] a,
			bit [LenW-1:0] l, bit [NumW-1:0] n);
		frag_result_t r;
		int f;
		r = '0;
		case (op)
			OP_ADD: r.tf = add_extent(a, l);
			OP_COUNT: begin
				f = locate_fragment(a);
				if (f >= 0) begin
					if (frag_alloc[f] != CntMax) frag_alloc[f]++;
					r.h = 1;
				end
			end
			OP_READ: begin
				if (n < used_cnt) begin
					r.ev = 1;
					r.st = frag_start[n];
					r.fr = frag_free[n];
					r.al = frag_alloc[n];
				end
			end
			default: begin
				used_cnt = 0;
				newest_ok = 0;
				newest_lone = 0;
			end
		endcase
		r.fc = used_cnt[CntW-1:0];
		return r;
	endfunction

	// result checker
	always @(posedge clk) begin
		frag_result_t want, got;
		if (arst_n === 1'b1 && done === 1'b1) begin
			got = {entry_valid, entry_start, entry_free, entry_alloc, hit, table_full,
				fragment_count};
			if (pending_results.size() == 0) begin
				$display("%0t: unexpected result %h", $time, got);
				errors++;
			end else begin
				want = pending_results.pop_front();
				if (want.ev !== got.ev)
					$display("%0t: entry_valid exp %h got %h", $time, want.ev, got.ev);
				if (want.st !== got.st)
					$display("%0t: entry_start exp %h got %h", $time, want.st, got.st);
				if (want.fr !== got.fr)
					$display("%0t: entry_free exp %h got %h", $time, want.fr, got.fr);
				if (want.al !== got.al)
					$display("%0t: entry_alloc exp %h got %h", $time, want.al, got.al);
				if (want.h !== got.h)
					$display("%0t: hit exp %h got %h", $time, want.h, got.h);
				if (want.tf !== got.tf)
					$display("%0t: table_full exp %h got %h", $time, want.tf, got.tf);
				if (want.fc !== got.fc)
					$display("%0t: fragment_count exp %h got %h", $time, want.fc, got.fc);
				if (want !== got) errors++;
			end
		end
	end

	// watchdog: cycles with no transfer of any kind
	always @(posedge clk) begin
		if ((start && !busy) || done || (psel && penable)) quiet_cycles <= 0;
		else quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WatchdogLimit) begin
			$display("free_space_fragment_table test failed");
			$finish;
		end
	end

	task automatic put_item(op_t op, bit [AddrW-1:0] a, bit [LenW-1:0] l,
			bit [NumW-1:0] n);
		int gap;
		gap = ($urandom_range(99) < idle_pct) ? $urandom_range(1, 5) : 0;
		if (gap > 0) begin
			start <= 0;
			repeat (gap) @(posedge clk);
		end
		start <= 1;
		opcode <= op;
		block_addr <= a;
		extent_length <= l;
		entry_number <= n;
		do @(posedge clk); while (busy);
		pending_results.push_back(predict_fragment(op, a, l, n));
	endtask

	task automatic wait_idle();
		start <= 0;
		@(posedge clk);
		while (pending_results.size() != 0) @(posedge clk);
		repeat (DrainCycles) @(posedge clk);
	endtask

	task automatic write_reg(logic [CfgAw-1:0] addr, bit [31:0] val);
		wait_idle();
		psel <= 1;
		penable <= 0;
		pwrite <= 1;
		paddr <= addr;
		pwdata <= val;
		@(posedge clk);
		penable <= 1;
		@(posedge clk);
		psel <= 0;
		penable <= 0;
		pwrite <= 0;
		if (addr == REG_WINDOW) win_size = val[FreeW-1:0];
		else prune_lvl = val[CntW-1:0];
	endtask

	task automatic test_directed();
		put_item(OP_READ, 0, 0, 0);
		put_item(OP_COUNT, 5, 0, 0);
		put_item(OP_ADD, 100, 10, 0);
		put_item(OP_ADD, 120, 24'hFFFFFF, 0);
		put_item(OP_ADD, 50, 3, 0);
		put_item(OP_ADD, 2000, 248, 0);
		put_item(OP_ADD, 2000, 7, 0);
		put_item(OP_ADD, 2300, 0, 0);
		put_item(OP_ADD, 2600, 1, 0);
		put_item(OP_COUNT, 2000, 0, 0);
		put_item(OP_COUNT, 2300, 0, 0);
		put_item(OP_COUNT, 2347, 0, 0);
		put_item(OP_COUNT, 2548, 0, 0);
		put_item(OP_COUNT, 99, 0, 0);
		put_item(OP_ADD, 31'h7FFFFFFF, 200, 0);
		put_item(OP_COUNT, 31'h7FFFFFFF, 0, 0);
		put_item(OP_READ, 0, 0, 1);
		put_item(OP_READ, 0, 0, 5);
		put_item(OP_READ, 0, 0, 12'hFFF);
		put_item(OP_CLEAR, 0, 0, 0);
		put_item(OP_READ, 0, 0, 0);
		put_item(OP_ADD, 31'h7FFFFF00, 1, 0);
		put_item(OP_READ, 0, 0, 0);
	endtask

	task automatic test_small_windows();
		write_reg(REG_WINDOW, 0);
		put_item(OP_CLEAR, 0, 0, 0);
		put_item(OP_ADD, 10, 0, 0);
		put_item(OP_ADD, 20, 5, 0);
		put_item(OP_COUNT, 10, 0, 0);
		write_reg(REG_WINDOW, 1);
		put_item(OP_ADD, 10, 0, 0);
		put_item(OP_ADD, 10, 3, 0);
		put_item(OP_ADD, 11, 1, 0);
		put_item(OP_ADD, 11, 0, 0);
		put_item(OP_COUNT, 11, 0, 0);
		put_item(OP_COUNT, 12, 0, 0);
		put_item(OP_READ, 0, 0, 1);
	endtask

	task automatic test_random(int n_items);
		bit [AddrW-1:0] a, base;
		bit [LenW-1:0] l;
		bit [NumW-1:0] n;
		int r, k;
		bit [31:0] w;
		for (int i = 0; i < n_items; i++) begin
			r = $urandom_range(99);
			w = (win_size == 0) ? 1 : win_size;
			base = (newest_ok && used_cnt > 0) ? frag_start[used_cnt - 1]
				: AddrW'($urandom);
			a = AddrW'($urandom);
			l = LenW'($urandom);
			n = NumW'($urandom);
			if (r < 45) begin
				k = $urandom_range(9);
				if (k < 3) a = base + AddrW'($urandom_range(w - 1));
				else if (k < 8) a = base + AddrW'(w) + AddrW'($urandom_range(3 * w));
				else if (k < 9) a = base - AddrW'($urandom_range(w));
				if ($urandom_range(7) != 0) l = LenW'($urandom_range(w));
				put_item(OP_ADD, a, l, n);
			end else if (r < 75) begin
				if (used_cnt > 0 && $urandom_range(9) != 0) begin
					k = $urandom_range(used_cnt - 1);
					a = frag_start[k];
					if ($urandom_range(3) != 0) a = a + AddrW'($urandom_range(w + 2));
				end
				put_item(OP_COUNT, a, l, n);
			end else if (r < 98) begin
				if (used_cnt > 0 && $urandom_range(4) != 0)
					n = NumW'($urandom_range(used_cnt - 1));
				put_item(OP_READ, a, l, n);
			end else begin
				put_item(OP_CLEAR, a, l, n);
			end
		end
	endtask

	initial begin
		arst_n <= 0;
		psel <= 0;
		penable <= 0;
		pwrite <= 0;
		paddr <= '0;
		pwdata <= '0;
		start <= 0;
		opcode <= OP_ADD;
		block_addr <= '0;
		extent_length <= '0;
		entry_number <= '0;
		errors = 0;
		quiet_cycles = 0;
		used_cnt = 0;
		newest_ok = 0;
		newest_lone = 0;
		win_size = 248;
		prune_lvl = 1000;
		idle_pct = 31;
		repeat (4) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		test_directed();
		test_small_windows();

		write_reg(REG_WINDOW, 16);
		write_reg(REG_PRUNE, 0);
		put_item(OP_CLEAR, 0, 0, 0);
		test_random(638);

		idle_pct = 79;
		write_reg(REG_WINDOW, 16'hFFFF);
		write_reg(REG_PRUNE, 30);
		test_random(638);

		idle_pct = 0;
		write_reg(REG_WINDOW, $urandom_range(2, 500));
		write_reg(REG_PRUNE, 4096);
		test_random(638);

		wait_idle();
		if (errors == 0) $display("free_space_fragment_table test passed");
		else $display("free_space_fragment_table test failed");
		$finish;
	end
endmodule
